@@ sv/cpp_pkg.sv @@
package cpp_pkg;

  localparam int MAX_CHARGES = 16;
  localparam int DIMENSIONS  = 3;

  localparam int IDX_W      = $clog2(MAX_CHARGES);
  localparam int NUM_W      = IDX_W + 1;
  localparam int DIM_W      = 2;
  localparam int COORD_W    = 32;
  localparam int CHARGE_W   = 16;
  localparam int POT_W      = 48;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int D2_W       = 2 * DIFF_W;
  localparam int ROOT_W     = D2_W / 2;
  localparam int SQREM_W    = ROOT_W + 3;
  localparam int QUO_W      = 48;
  localparam int DREM_W     = ROOT_W + 1;
  localparam int ACC_W      = QUO_W + NUM_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W      = 6;
  localparam int ENTRY_W    = 3 * COORD_W + CHARGE_W;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef struct packed {
    logic                       func;
    logic [3:0]                 slot;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic signed [CHARGE_W-1:0] charge;
    logic                       last_point;
  } cpp_in_t;

  typedef struct packed {
    logic signed [POT_W-1:0] potential;
    logic                    at_nucleus;
    logic                    saturated;
    logic                    last_out;
  } cpp_out_t;

  typedef struct packed {
    logic             load;
    logic             start;
    logic             clr_d2;
    logic             sq;
    logic             add_d2;
    logic [DIM_W-1:0] dim;
    logic             root_init;
    logic             root_step;
    logic             div_step;
    logic             accum;
    logic             nuc_set;
    logic             emit;
    logic [IDX_W-1:0] idx;
  } cpp_cmd_t;

  typedef struct packed {
    logic [NUM_W-1:0] n;
    logic             d2_zero;
    logic             out_free;
  } cpp_status_t;

endpackage

@@ sv/cpp_ram.sv @@
module cpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/cpp_ctrl.sv @@
module cpp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                func,
  output logic                in_ready,
  input  cpp_pkg::cpp_status_t status,
  output cpp_pkg::cpp_cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_SQ   = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_ROOT = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_NEXT = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t                     state, state_next;
  logic [cpp_pkg::CNT_W-1:0]  cnt, cnt_next;
  logic [cpp_pkg::IDX_W-1:0]  idx, idx_next;
  logic                       skip, skip_next;
  logic [cpp_pkg::NUM_W-1:0]  idx_inc;

  assign idx_inc = {1'b0, idx} + cpp_pkg::NUM_W'(1);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    skip_next  = skip;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.idx    = idx;
    cmd.dim    = cnt[cpp_pkg::DIM_W-1:0];
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == cpp_pkg::FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            idx_next   = '0;
            state_next = (status.n == '0) ? S_EMIT : S_READ;
          end
        end
      end
      S_READ: begin
        cmd.clr_d2 = 1'b1;
        cnt_next   = '0;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq     = (cnt < cpp_pkg::CNT_W'(cpp_pkg::DIMENSIONS));
        cmd.add_d2 = (cnt != '0);
        cnt_next   = cnt + cpp_pkg::CNT_W'(1);
        if (cnt == cpp_pkg::CNT_W'(cpp_pkg::DIMENSIONS)) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        cnt_next = '0;
        if (status.d2_zero) begin
          skip_next  = 1'b1;
          state_next = S_NEXT;
        end else begin
          skip_next     = 1'b0;
          cmd.root_init = 1'b1;
          state_next    = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + cpp_pkg::CNT_W'(1);
        if (cnt == cpp_pkg::CNT_W'(cpp_pkg::ROOT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + cpp_pkg::CNT_W'(1);
        if (cnt == cpp_pkg::CNT_W'(cpp_pkg::DIV_STEPS - 1)) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.accum   = !skip;
        cmd.nuc_set = skip;
        idx_next    = idx_inc[cpp_pkg::IDX_W-1:0];
        state_next  = (idx_inc == status.n) ? S_EMIT : S_READ;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      idx   <= '0;
      skip  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
      skip  <= skip_next;
    end
  end

endmodule

@@ sv/cpp_dp.sv @@
module cpp_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [4:0]           cfg_data,
  input  cpp_pkg::cpp_in_t     in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output cpp_pkg::cpp_out_t    out_data,
  input  cpp_pkg::cpp_cmd_t    cmd,
  output cpp_pkg::cpp_status_t status
);

  localparam int CW = cpp_pkg::COORD_W;

  logic [4:0]                       atoms_in_use;
  logic signed [CW-1:0]             px, py, pz;
  logic                             last;
  logic [cpp_pkg::ENTRY_W-1:0]      rdata;
  logic signed [CW-1:0]             cx, cy, cz;
  logic signed [cpp_pkg::CHARGE_W-1:0] cval;
  logic                             ram_we;

  logic signed [CW-1:0]             sel_p, sel_c;
  logic signed [cpp_pkg::DIFF_W-1:0] diff;
  logic [cpp_pkg::DIFF_W-1:0]       mag;
  logic [cpp_pkg::D2_W-1:0]         prod, d2;

  logic [cpp_pkg::D2_W-1:0]         sq_src;
  logic [cpp_pkg::SQREM_W-1:0]      sq_rem, sq_sh, sq_trial;
  logic [cpp_pkg::ROOT_W-1:0]       root;

  logic [cpp_pkg::QUO_W-1:0]        num, quo;
  logic [cpp_pkg::DREM_W-1:0]       drem, d_sh;
  logic                             csign;

  logic signed [cpp_pkg::ACC_W-1:0] acc, term;
  logic                             nuc;
  logic                             pos_ovf, neg_ovf;
  logic [cpp_pkg::CHARGE_W-1:0]     cmag;

  assign ram_we = cmd.load && ({1'b0, in_data.slot} < 5'(cpp_pkg::MAX_CHARGES));

  cpp_ram #(
    .WIDTH(cpp_pkg::ENTRY_W),
    .DEPTH(cpp_pkg::MAX_CHARGES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_data.slot[cpp_pkg::IDX_W-1:0]),
    .wdata({in_data.coord_x, in_data.coord_y, in_data.coord_z, in_data.charge}),
    .raddr(cmd.idx),
    .rdata(rdata)
  );

  assign {cx, cy, cz, cval} = rdata;

  always_comb begin
    case (cmd.dim)
      2'd0:    begin sel_p = px; sel_c = cx; end
      2'd1:    begin sel_p = py; sel_c = cy; end
      default: begin sel_p = pz; sel_c = cz; end
    endcase
    diff = {sel_p[CW-1], sel_p} - {sel_c[CW-1], sel_c};
    mag  = diff[cpp_pkg::DIFF_W-1] ? cpp_pkg::DIFF_W'(-diff) : diff;
  end

  // one root bit per step: bring down two radicand bits, try root*4+1
  assign sq_sh    = {sq_rem[cpp_pkg::SQREM_W-3:0], sq_src[cpp_pkg::D2_W-1 -: 2]};
  assign sq_trial = {1'b0, root, 2'b01};
  // one quotient bit per step against the root
  assign d_sh     = {drem[cpp_pkg::DREM_W-2:0], num[cpp_pkg::QUO_W-1]};

  assign cmag = cval[cpp_pkg::CHARGE_W-1] ? cpp_pkg::CHARGE_W'(-cval) : cval;
  assign term = csign ? -cpp_pkg::ACC_W'(quo) : cpp_pkg::ACC_W'(quo);

  assign pos_ovf = !acc[cpp_pkg::ACC_W-1] && (acc[cpp_pkg::ACC_W-2:cpp_pkg::POT_W-1] != '0);
  assign neg_ovf = acc[cpp_pkg::ACC_W-1] && (acc[cpp_pkg::ACC_W-2:cpp_pkg::POT_W-1] != '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      atoms_in_use <= '0;
    end else if (cfg_we) begin
      atoms_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px   <= in_data.coord_x;
      py   <= in_data.coord_y;
      pz   <= in_data.coord_z;
      last <= in_data.last_point;
      acc  <= '0;
      nuc  <= 1'b0;
    end
    if (cmd.sq) begin
      prod <= mag * mag;
    end
    if (cmd.clr_d2) begin
      d2 <= '0;
    end else if (cmd.add_d2) begin
      d2 <= d2 + prod;
    end
    if (cmd.root_init) begin
      sq_src <= d2;
      sq_rem <= '0;
      root   <= '0;
      num    <= {cmag, 32'd0};
      csign  <= cval[cpp_pkg::CHARGE_W-1];
      drem   <= '0;
      quo    <= '0;
    end
    if (cmd.root_step) begin
      sq_src <= sq_src << 2;
      if (sq_sh >= sq_trial) begin
        sq_rem <= sq_sh - sq_trial;
        root   <= {root[cpp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem <= sq_sh;
        root   <= {root[cpp_pkg::ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.div_step) begin
      num <= num << 1;
      if (d_sh >= {1'b0, root}) begin
        drem <= d_sh - {1'b0, root};
        quo  <= {quo[cpp_pkg::QUO_W-2:0], 1'b1};
      end else begin
        drem <= d_sh;
        quo  <= {quo[cpp_pkg::QUO_W-2:0], 1'b0};
      end
    end
    if (cmd.accum) begin
      acc <= acc + term;
    end
    if (cmd.nuc_set) begin
      nuc <= 1'b1;
    end
    if (cmd.emit) begin
      out_data.potential  <= pos_ovf ? {1'b0, {(cpp_pkg::POT_W-1){1'b1}}} :
                             neg_ovf ? {1'b1, {(cpp_pkg::POT_W-1){1'b0}}} :
                             acc[cpp_pkg::POT_W-1:0];
      out_data.at_nucleus <= nuc;
      out_data.saturated  <= pos_ovf || neg_ovf;
      out_data.last_out   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.n        = (atoms_in_use > 5'(cpp_pkg::MAX_CHARGES)) ?
                           cpp_pkg::NUM_W'(cpp_pkg::MAX_CHARGES) :
                           atoms_in_use[cpp_pkg::NUM_W-1:0];
  assign status.d2_zero  = (d2 == '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

@@ sv/coulomb_point_charge_potential.sv @@
// Coulomb potential of up to 16 point charges. A load item (func 0) writes
// one charge slot and returns nothing. An evaluate item (func 1) returns
// the sum of charge over distance in Q16.32, saturated, for the first
// atoms_in_use slots, with a count above 16 taken as 16. A slot at zero
// distance is skipped and flags at_nucleus. Each summed charge runs on one
// shared unit: a fetch, a squared-distance pass through one 33x33
// multiplier, a check, a 33-step bit-serial square root, a 48-step
// bit-serial divide and an accumulate. A charge that the point lies on
// stops after the check. The result of an evaluate item is held back while
// the previous result waits for out_ready, and the block takes one item at
// a time. Summing a slot that was never loaded gives an undefined potential.
module coulomb_point_charge_potential (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cpp_pkg::cpp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cpp_pkg::cpp_out_t out_data,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_data
);

  cpp_pkg::cpp_cmd_t    cmd;
  cpp_pkg::cpp_status_t status;

  cpp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .func    (in_data.func),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  cpp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .cmd      (cmd),
    .status   (status)
  );

endmodule
